### hdl/ordered_record_list_engine_top_defines.svh
// Assertion macros for the ordered record list engine.
// Needs a clock named clock and a reset named reset in the using module.
`ifndef ORDERED_RECORD_LIST_ENGINE_TOP_DEFINES_SVH
`define ORDERED_RECORD_LIST_ENGINE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define ORLE_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ordered record list engine: assertion failed");
`define ORLE_NEVER(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("ordered record list engine: forbidden condition seen");
`else
`define ORLE_ASSERT(label, prop)
`define ORLE_NEVER(label, cond)
`endif
`endif

### hdl/ordrl_pkg.sv
// Shared types and constants of the ordered record list engine.
// No dependencies; used by ordrl_cell and ordered_record_list_engine_top.
package ordrl_pkg;

   localparam int CAPACITY      = 16;
   localparam int COUNT_W       = $clog2(CAPACITY + 1);
   localparam int ENTRY_COUNT_W = 5;
   localparam int MODE_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int HEAD_W        = 64;
   localparam int TAIL_W        = 24;
   localparam int GRADE_W       = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_INSERT     = 3'd2,
      MODE_POP_FRONT  = 3'd3,
      MODE_POP_BACK   = 3'd4,
      MODE_REMOVE     = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [HEAD_W-1:0]  head;
      logic [TAIL_W-1:0]  tail;
      logic [GRADE_W-1:0] grade;
   } record_type;

   // Broadcast to every cell in the chain
   typedef struct packed {
      logic       en;       // commit the shift this cycle
      logic       ins;      // opening a gap (push or insert), else closing one
      mode_type   mode;
      record_type item;
   } cell_ctrl_type;

endpackage

### hdl/ordrl_cell.sv
// One slot of the record chain: holds a record, decides its own hit and shifts.
// Depends on ordrl_pkg.
module ordrl_cell (
   input  logic                     clock,
   input  ordrl_pkg::cell_ctrl_type ctrl,
   input  logic                     occupied,
   input  logic                     at_count,
   input  logic                     at_last,
   input  ordrl_pkg::record_type    left_rec,
   input  ordrl_pkg::record_type    right_rec,
   input  logic                     before_in,
   output logic                     before_out,
   output logic                     first,
   output ordrl_pkg::record_type    rec
);
   import ordrl_pkg::*;

   record_type rec_ff;
   record_type rec_in;
   logic       hit;

   // Hit marks a candidate position; the first hit along the chain wins
   always_comb begin
      case (ctrl.mode)
         MODE_PUSH_FRONT: hit = 1'b1;
         MODE_PUSH_BACK:  hit = at_count;
         MODE_INSERT:     hit = (occupied && (rec_ff.grade >= ctrl.item.grade)) || at_count;
         MODE_POP_FRONT:  hit = occupied;
         MODE_POP_BACK:   hit = at_last;
         MODE_REMOVE:     hit = occupied && (rec_ff.head == ctrl.item.head)
                                         && (rec_ff.tail == ctrl.item.tail);
         default:         hit = 1'b0;
      endcase
   end

   assign before_out = before_in | hit;
   assign first      = hit & ~before_in;
   assign rec        = rec_ff;

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.en) begin
         if (ctrl.ins) begin
            if (before_in) begin
               rec_in = left_rec;
            end else if (hit) begin
               rec_in = ctrl.item;
            end
         end else if (before_out) begin
            rec_in = right_rec;
         end
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

endmodule

### hdl/ordered_record_list_engine_top.sv
// Top level of the ordered record list engine: chain of record cells plus result register.
// Depends on ordrl_pkg, ordrl_cell and ordered_record_list_engine_top_defines.svh.
//
// A bounded list of up to CAPACITY (16) records, each an 11-character name
// (8 head, 3 tail characters) and an 8-bit grade, held in a row of cells in
// list order, front in cell 0. On each transaction all cells compare against
// the request at once, the hit flags ripple along the chain to find the first
// matching position, and each cell takes its left neighbour, its right
// neighbour, the new record or holds, at the same edge. Throughput is one
// transaction per clock while the result register is free or being drained;
// the result is registered in the rsp_ registers, and a new request is taken
// in the cycle the waiting result is taken, so a full-rate consumer sees
// back-to-back results. The critical path is the hit ripple across all cells.
// Reset clears only the count and the result valid; cells beyond the count are never read.
module ordered_record_list_engine_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ordrl_pkg::MODE_W-1:0]  req_mode,
   input  logic [ordrl_pkg::HEAD_W-1:0]  req_name_head_chars,
   input  logic [ordrl_pkg::TAIL_W-1:0]  req_name_tail_chars,
   input  logic [ordrl_pkg::GRADE_W-1:0] req_grade,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ordrl_pkg::STATUS_W-1:0] rsp_status,
   output logic [ordrl_pkg::HEAD_W-1:0]  rsp_out_name_head,
   output logic [ordrl_pkg::TAIL_W-1:0]  rsp_out_name_tail,
   output logic [ordrl_pkg::GRADE_W-1:0] rsp_out_grade,
   output logic [ordrl_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import ordrl_pkg::*;
   `include "ordered_record_list_engine_top_defines.svh"

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         status_ff;
   status_type         status_in;
   record_type         out_rec_ff;
   record_type         out_rec_in;

   cell_ctrl_type      ctrl;
   mode_type           mode;
   record_type         cell_rec [CAPACITY];
   logic [CAPACITY:0]  hit_seen;
   logic [CAPACITY-1:0] first_vec;
   record_type         picked;
   logic               accept;
   logic               is_ins;
   logic               is_rem;
   logic               full;
   logic               found;

   assign mode      = mode_type'(req_mode);
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign full      = (count_ff == COUNT_W'(CAPACITY));
   assign is_ins    = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK)
                   || (mode == MODE_INSERT);
   assign is_rem    = (mode == MODE_POP_FRONT) || (mode == MODE_POP_BACK)
                   || (mode == MODE_REMOVE);
   assign found     = hit_seen[CAPACITY];

   // Broadcast the request; commit only when the operation succeeds
   always_comb begin
      ctrl.en         = accept && ((is_ins && !full) || (is_rem && found));
      ctrl.ins        = is_ins;
      ctrl.mode       = mode;
      ctrl.item.head  = req_name_head_chars;
      ctrl.item.tail  = req_name_tail_chars;
      ctrl.item.grade = req_grade;
   end

   assign hit_seen[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      record_type left_rec;
      record_type right_rec;

      if (i == 0) begin : g_head
         assign left_rec = ctrl.item;
      end else begin : g_mid
         assign left_rec = cell_rec[i-1];
      end

      // The last cell has nobody to its right: it holds, and drops out of the count
      if (i == CAPACITY - 1) begin : g_tail
         assign right_rec = cell_rec[i];
      end else begin : g_body
         assign right_rec = cell_rec[i+1];
      end

      ordrl_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (COUNT_W'(i) < count_ff),
         .at_count   (count_ff == COUNT_W'(i)),
         .at_last    (count_ff == COUNT_W'(i + 1)),
         .left_rec   (left_rec),
         .right_rec  (right_rec),
         .before_in  (hit_seen[i]),
         .before_out (hit_seen[i+1]),
         .first      (first_vec[i]),
         .rec        (cell_rec[i])
      );
   end

   // Select the removed record from the single first hit
   always_comb begin
      picked = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         picked = picked | (first_vec[i] ? cell_rec[i] : record_type'('0));
      end
   end

   // Result and count for the transaction
   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      out_rec_in   = out_rec_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         out_rec_in   = '0;
         if (is_ins) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_DONE;
               count_in  = count_ff + COUNT_W'(1);
            end
         end else if (is_rem && found) begin
            status_in  = STATUS_DONE;
            out_rec_in = picked;
            count_in   = count_ff - COUNT_W'(1);
         end else begin
            status_in = STATUS_MISS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload of the result: no reset needed
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      out_rec_ff <= out_rec_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_out_name_head = out_rec_ff.head;
   assign rsp_out_name_tail = out_rec_ff.tail;
   assign rsp_out_grade     = out_rec_ff.grade;
   assign rsp_entry_count   = ENTRY_COUNT_W'(count_ff);

   `ORLE_NEVER(a_count_bound, count_ff > COUNT_W'(CAPACITY))
   `ORLE_ASSERT(a_one_first_hit, $onehot0(first_vec))
   `ORLE_ASSERT(a_full_holds, (accept && is_ins && full) |=> (count_ff == $past(count_ff)))
   `ORLE_ASSERT(a_remove_shrinks, (accept && is_rem && found) |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
   `ORLE_ASSERT(a_rsp_count, rsp_valid_ff |-> (rsp_entry_count == ENTRY_COUNT_W'(count_ff)))

endmodule

### verif/ordered_record_list_engine_top_test.sv
// Self-checking testbench for the ordered record list engine: pushes, ordered inserts,
// pops and removals under random idling, each result checked against a local list model.
// Depends on ordrl_pkg and ordered_record_list_engine_top.
module ordered_record_list_engine_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ordrl_pkg::*;

   localparam int NAME_W          = HEAD_W + TAIL_W;
   localparam int POOL_SIZE       = 8;
   localparam int RANDOM_ITEMS    = 650;
   localparam int HOLD_OFF_CYCLES = 80;    // long receiver hold-off
   localparam int DRAIN_CYCLES    = 8;     // result register latency plus slack
   localparam int QUIET_LIMIT     = 2000;  // cycles with no transaction on either side
   localparam int PRINT_CAP       = 100;

   // Mode codes the block must treat as no-ops
   localparam logic [MODE_W-1:0] MODE_SPARE_LOW  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HIGH = 3'd7;

   // Flips the last name character, which sits after a zero character in the
   // zero-embedded pool name
   localparam logic [NAME_W-1:0] LAST_CHAR_BIT = NAME_W'(24'h80_0000);

   typedef struct packed {
      status_type                status;
      logic [HEAD_W-1:0]         head;
      logic [TAIL_W-1:0]         tail;
      logic [GRADE_W-1:0]        grade;
      logic [ENTRY_COUNT_W-1:0]  count;
   } outcome_type;

   // Local copy of the list: applies each accepted transaction and queues the
   // result it must produce, then checks results in order as they arrive.
   class list_tracker;
      record_type  slots[CAPACITY];
      int          held = 0;
      int          failures = 0;
      outcome_type outcomes_due[$];

      function int pending();
         return outcomes_due.size();
      endfunction

      task flag_mismatch(string what, logic [NAME_W-1:0] got, logic [NAME_W-1:0] want);
         failures++;
         if (failures <= PRINT_CAP) begin
            $display("%0t: mismatch on %s: got %h, wanted %h", $realtime, what, got, want);
         end
      endtask

      function void note_request(logic [MODE_W-1:0] mode, record_type item);
         outcome_type due;
         int          pos;
         due = '0;
         due.status = STATUS_DONE;
         pos = 0;
         case (mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
               if (held >= CAPACITY) begin
                  due.status = STATUS_FULL;
               end else begin
                  if (mode == MODE_PUSH_BACK) begin
                     pos = held;
                  end else if (mode == MODE_INSERT) begin
                     while (pos < held && slots[pos].grade < item.grade) pos++;
                  end
                  for (int i = held; i > pos; i--) slots[i] = slots[i-1];
                  slots[pos] = item;
                  held++;
               end
            end
            MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE: begin
               if (held == 0) begin
                  due.status = STATUS_MISS;
               end else begin
                  if (mode == MODE_POP_BACK) begin
                     pos = held - 1;
                  end else if (mode == MODE_REMOVE) begin
                     while (pos < held &&
                            {slots[pos].head, slots[pos].tail} != {item.head, item.tail})
                        pos++;
                  end
                  if (pos >= held) begin
                     due.status = STATUS_MISS;
                  end else begin
                     due.head  = slots[pos].head;
                     due.tail  = slots[pos].tail;
                     due.grade = slots[pos].grade;
                     for (int i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
                     held--;
                  end
               end
            end
            default: begin
               due.status = STATUS_MISS;
            end
         endcase
         due.count = ENTRY_COUNT_W'(held);
         outcomes_due.push_back(due);
      endfunction

      task check_outcome(logic [STATUS_W-1:0] status, logic [HEAD_W-1:0] head,
                         logic [TAIL_W-1:0] tail, logic [GRADE_W-1:0] grade,
                         logic [ENTRY_COUNT_W-1:0] count);
         outcome_type due;
         if (outcomes_due.size() == 0) begin
            flag_mismatch("result with no transaction outstanding", '0, '0);
         end else begin
            due = outcomes_due.pop_front();
            if (status !== due.status) flag_mismatch("status", status, due.status);
            if (head !== due.head)     flag_mismatch("name head", head, due.head);
            if (tail !== due.tail)     flag_mismatch("name tail", tail, due.tail);
            if (grade !== due.grade)   flag_mismatch("grade", grade, due.grade);
            if (count !== due.count)   flag_mismatch("entry count", count, due.count);
         end
      endtask
   endclass

   // Every input starts at a known value; reset is held from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode = '0;
   logic [HEAD_W-1:0]        req_name_head_chars = '0;
   logic [TAIL_W-1:0]        req_name_tail_chars = '0;
   logic [GRADE_W-1:0]       req_grade = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [HEAD_W-1:0]        rsp_out_name_head;
   logic [TAIL_W-1:0]        rsp_out_name_tail;
   logic [GRADE_W-1:0]       rsp_out_grade;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;

   list_tracker       tracker = new;
   logic [NAME_W-1:0] name_pool[POOL_SIZE];
   int unsigned       quiet_cycles = 0;
   int unsigned       burst_left = 0;
   bit                gaps_on = 1'b1;
   int                hold_offs_requested = 0;
   int                hold_offs_done = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_record_list_engine_top DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_name_head_chars (req_name_head_chars),
      .req_name_tail_chars (req_name_tail_chars),
      .req_grade           (req_grade),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_out_name_head   (rsp_out_name_head),
      .rsp_out_name_tail   (rsp_out_name_tail),
      .rsp_out_grade       (rsp_out_grade),
      .rsp_entry_count     (rsp_entry_count)
   );

   // Observe both channels at the rising edge. Check a result before noting a
   // request taken at the same edge: the result always belongs to an earlier
   // transaction, since the block registers its result.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            tracker.check_outcome(rsp_status, rsp_out_name_head, rsp_out_name_tail,
                                  rsp_out_grade, rsp_entry_count);
         end
         if (req_valid && req_ready) begin
            tracker.note_request(req_mode,
                                 {req_name_head_chars, req_name_tail_chars, req_grade});
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // End the run if nothing moves for far longer than the longest legal stall
   // (the receiver hold-off, plus sender gaps and heavy random stalls).
   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < QUIET_LIMIT);
      $display("[ordered_record_list_engine_top] ERROR");
      $finish;
   end

   // Receiver: stretches of random length, each with its own stall density,
   // zero among them. A requested hold-off drops ready for a long stretch,
   // counted here, so the result register fills and the block stalls its input.
   initial begin : receiver
      int unsigned stretch;
      int unsigned stall_pct;
      stretch = 0;
      stall_pct = 0;
      forever begin
         @(negedge clock);
         if (hold_offs_done < hold_offs_requested) begin
            hold_offs_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(20, 150);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 60;
                  default: stall_pct = 90;
               endcase
            end
            stretch--;
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Sender tasks start and end just after a falling edge, so each input gets
   // at most one assignment per time step.
   task automatic pause_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // Offer one transaction and hold it until it is taken. Bursts of random
   // length, with random gaps between them while gaps are enabled.
   task automatic offer(logic [MODE_W-1:0] mode, logic [NAME_W-1:0] name,
                        logic [GRADE_W-1:0] grade);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (gaps_on) pause_sender($urandom_range(1, 6));
      end
      burst_left--;
      req_valid           <= 1'b1;
      req_mode            <= mode;
      req_name_head_chars <= name[NAME_W-1:TAIL_W];
      req_name_tail_chars <= name[TAIL_W-1:0];
      req_grade           <= grade;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Hold the sender off until every outstanding result has come back; wait
   // at least one falling edge so the next drive lands in a later time step
   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (tracker.pending() != 0);
   endtask

   function automatic logic [NAME_W-1:0] random_name();
      return NAME_W'({$urandom, $urandom, $urandom});
   endfunction

   function automatic logic [NAME_W-1:0] pool_name();
      return name_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   function automatic logic [NAME_W-1:0] flip_bit(logic [NAME_W-1:0] name);
      return name ^ (NAME_W'(1) << $urandom_range(0, NAME_W - 1));
   endfunction

   // Crowd grades into a narrow band often, so ordered inserts meet ties
   function automatic logic [GRADE_W-1:0] random_grade();
      case ($urandom_range(0, 3))
         0:       return GRADE_W'($urandom_range(60, 64));
         1:       return $urandom_range(0, 1) ? '1 : '0;
         default: return GRADE_W'($urandom);
      endcase
   endfunction

   // One random transaction. store_pct weighs pushes and inserts against
   // removals, so blocks can fill the list, drain it, or hover. Names come
   // mostly from a small pool so duplicates and hits are common; removals
   // mostly target a record that is held, now and then one bit off.
   task automatic random_transaction(int unsigned store_pct);
      logic [MODE_W-1:0] mode;
      logic [NAME_W-1:0] name;
      int unsigned       roll;
      int unsigned       idx;
      roll = $urandom_range(0, 99);
      name = random_name();
      if (roll < 3) begin
         mode = $urandom_range(0, 1) ? MODE_SPARE_LOW : MODE_SPARE_HIGH;
      end else if (roll < 3 + store_pct) begin
         mode = MODE_W'($urandom_range(MODE_PUSH_FRONT, MODE_INSERT));
         roll = $urandom_range(0, 4);
         if (roll < 3) begin
            name = pool_name();
         end else if (roll == 3) begin
            name = flip_bit(pool_name());
         end
      end else begin
         if ($urandom_range(0, 1) == 1) begin
            mode = MODE_REMOVE;
         end else begin
            mode = MODE_W'($urandom_range(MODE_POP_FRONT, MODE_POP_BACK));
         end
         roll = $urandom_range(0, 9);
         if (tracker.held > 0 && roll < 6) begin
            idx  = $urandom_range(0, tracker.held - 1);
            name = {tracker.slots[idx].head, tracker.slots[idx].tail};
            if (roll == 5) name = flip_bit(name);
         end else if (roll < 8) begin
            name = pool_name();
         end
      end
      offer(mode, name, random_grade());
   endtask

   initial begin : stimulus
      int unsigned issued;
      int unsigned block_items;
      int unsigned block_no;
      int unsigned store_pct;
      int          pick;
      for (int i = 0; i < POOL_SIZE; i++) name_pool[i] = random_name();
      name_pool[0] = '1;
      name_pool[1] = '0;
      // 'A', then a zero character, then random characters that still count
      name_pool[2][TAIL_W+15:TAIL_W] = 16'h0041;

      // Hold reset from time zero, release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Removals on the empty list, and the spare mode codes
      offer(MODE_POP_FRONT, name_pool[3], '0);
      offer(MODE_POP_BACK, name_pool[3], '1);
      offer(MODE_REMOVE, name_pool[0], '0);
      offer(MODE_SPARE_LOW, name_pool[0], '1);
      offer(MODE_SPARE_HIGH, name_pool[1], '0);

      // Extremes of name and grade, then inserts that tie on grade and must
      // land ahead of the equal entry
      offer(MODE_PUSH_BACK, name_pool[0], '1);
      offer(MODE_PUSH_FRONT, name_pool[1], '0);
      offer(MODE_INSERT, name_pool[3], 8'd128);
      offer(MODE_INSERT, name_pool[4], 8'd128);

      // Exact match: a difference after the zero character must miss
      offer(MODE_PUSH_BACK, name_pool[2], 8'd7);
      offer(MODE_REMOVE, name_pool[2] ^ LAST_CHAR_BIT, '0);
      offer(MODE_REMOVE, name_pool[2], '0);

      // Duplicate names: removal takes the first one in list order
      offer(MODE_PUSH_BACK, name_pool[3], 8'd9);
      offer(MODE_REMOVE, name_pool[3], '0);

      // Fill to capacity, overflow with a push and an insert, then pop both ends
      while (tracker.held < CAPACITY) offer(MODE_PUSH_BACK, random_name(), random_grade());
      offer(MODE_PUSH_FRONT, name_pool[5], '1);
      offer(MODE_INSERT, name_pool[5], '0);
      offer(MODE_POP_FRONT, name_pool[5], '0);
      offer(MODE_POP_BACK, name_pool[5], '0);
      wait_for_results();

      // Random blocks cycling through fill, drain and balanced mixes. Two of
      // them run without sender gaps while the receiver holds off.
      issued = 0;
      block_no = 0;
      while (issued < RANDOM_ITEMS) begin
         block_items = $urandom_range(30, 70);
         case (block_no % 3)
            0:       store_pct = 75;
            1:       store_pct = 20;
            default: store_pct = 48;
         endcase
         gaps_on = ($urandom_range(0, 3) != 0);
         if (block_no == 2 || block_no == 7) begin
            hold_offs_requested++;
            gaps_on = 1'b0;
         end
         repeat (block_items) random_transaction(store_pct);
         issued += block_items;
         pick = $urandom_range(0, 2);
         if (pick == 0) wait_for_results();
         block_no++;
      end

      // Drain, then leave room for any stray result to show up
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("[ordered_record_list_engine_top] OK");
      end else begin
         $display("[ordered_record_list_engine_top] ERROR");
      end
      $finish;
   end

endmodule
